// ===== sv/asc_pkg.sv =====
`timescale 1ns / 1ps
package asc_pkg;
   localparam logic [63:0] IV_WORD = 64'h80400c0600000000;
   localparam logic [63:0] PAD_TOP = 64'h8000000000000000;
   localparam int ROUNDS_A = 12;
   localparam int ROUNDS_B = 6;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_AD = 2'd1;
   localparam logic [1:0] CMD_TEXT = 2'd2;
   localparam logic [1:0] CMD_FINISH = 2'd3;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_AD = 2'd1;
   localparam logic [1:0] PH_TEXT = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   localparam logic [2:0] REG_KEY_HIGH = 3'd0;
   localparam logic [2:0] REG_KEY_LOW = 3'd1;
   localparam logic [2:0] REG_NONCE_HIGH = 3'd2;
   localparam logic [2:0] REG_NONCE_LOW = 3'd3;
   localparam logic [2:0] REG_DECRYPT = 3'd4;

   typedef logic [63:0] word_type;
   typedef word_type [4:0] state_type;

   function automatic word_type lead_mask(input logic [3:0] n);
      word_type m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < int'(n)) begin
            m[63-8*i -: 8] = 8'hff;
         end
      end
      return m;
   endfunction

   function automatic word_type pad_at(input logic [3:0] n);
      word_type p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (i == int'(n)) begin
            p[63-8*i] = 1'b1;
         end
      end
      return p;
   endfunction
endpackage

// ===== sv/asc_round.sv =====
`timescale 1ns / 1ps
module asc_round
   import asc_pkg::*;
(
   input  state_type  s_in,
   input  logic [3:0] round_idx,
   output state_type  s_out
);
   word_type x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
   logic [7:0] rc;

   always_comb begin
      rc = 8'hf0 - 8'({4'd0, round_idx} * 8'h0f);
      x0 = s_in[0];
      x1 = s_in[1];
      x2 = s_in[2] ^ {56'd0, rc};
      x3 = s_in[3];
      x4 = s_in[4];
      x0 = x0 ^ x4;
      x4 = x4 ^ x3;
      x2 = x2 ^ x1;
      t0 = ~x0 & x1;
      t1 = ~x1 & x2;
      t2 = ~x2 & x3;
      t3 = ~x3 & x4;
      t4 = ~x4 & x0;
      x0 = x0 ^ t1;
      x1 = x1 ^ t2;
      x2 = x2 ^ t3;
      x3 = x3 ^ t4;
      x4 = x4 ^ t0;
      x1 = x1 ^ x0;
      x0 = x0 ^ x4;
      x3 = x3 ^ x2;
      x2 = ~x2;
      s_out[0] = x0 ^ {x0[18:0], x0[63:19]} ^ {x0[27:0], x0[63:28]};
      s_out[1] = x1 ^ {x1[60:0], x1[63:61]} ^ {x1[38:0], x1[63:39]};
      s_out[2] = x2 ^ {x2[0], x2[63:1]} ^ {x2[5:0], x2[63:6]};
      s_out[3] = x3 ^ {x3[9:0], x3[63:10]} ^ {x3[16:0], x3[63:17]};
      s_out[4] = x4 ^ {x4[6:0], x4[63:7]} ^ {x4[40:0], x4[63:41]};
   end
endmodule

// ===== sv/ascon128_aead_engine_top.sv =====
`timescale 1ns / 1ps
// channel | valid     | stall     | payload
// req     | req_valid | req_stall | command, data_in, byte_count, last_block, expected tag
// rsp     | rsp_valid | rsp_stall | data_out, valid_bytes, tag_high/low, tag_match, status
// csr     | csr_write | -         | csr_index, csr_data
// one permutation round per cycle through a single shared round unit
// rsp_valid rises after acceptance once start and finish have run the ROUNDS_A permutation, a word
// has run p6, or at once with no permutation for a partial last text word, an empty ad close or a rejected command
// implicit close of associated data adds a p6 run (none when none was absorbed),
// a full last associated-data word adds a further p6 run for the pad
// reset is synchronous and clears the state words, phase and control
// req_stall is high from acceptance until the result transaction is taken
module ascon128_aead_engine_top
   import asc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_data_in,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last_block,
   input  logic [63:0] req_expected_tag_high,
   input  logic [63:0] req_expected_tag_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_data_out,
   output logic [3:0]  rsp_valid_bytes,
   output logic [63:0] rsp_tag_high,
   output logic [63:0] rsp_tag_low,
   output logic        rsp_tag_match,
   output logic        rsp_status,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   // sequencer steps
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_PERM = 4'd2;
   localparam logic [3:0] S_RESP = 4'd3;

   // follow-up actions after a permutation
   localparam logic [3:0] A_START_END = 4'd0;
   localparam logic [3:0] A_CLOSE_END = 4'd1;
   localparam logic [3:0] A_AD_END = 4'd2;
   localparam logic [3:0] A_AD_PAD = 4'd3;
   localparam logic [3:0] A_TEXT_END = 4'd4;
   localparam logic [3:0] A_FIN_END = 4'd5;

   logic [3:0]  st_ff, st_in, act_ff, act_in, rnd_ff, rnd_in, left_ff, left_in;
   state_type   x_ff, x_in, x_rnd;
   logic [1:0]  phase_ff, phase_in;
   logic        adc_ff, adc_in, ads_ff, ads_in, dec_ff;
   word_type    kh_ff, kl_ff, nh_ff, nl_ff;
   logic [1:0]  cmd_ff;
   word_type    d_ff, eh_ff, el_ff;
   logic [3:0]  n_ff;
   logic        last_ff;
   logic        rv_ff, rv_in;
   word_type    do_ff, do_in, th_ff, th_in, tl_ff, tl_in;
   logic [3:0]  vb_ff, vb_in;
   logic        tm_ff, tm_in, stat_ff, stat_in;
   word_type    m, dm;

   asc_round u_round (.s_in(x_ff), .round_idx(rnd_ff), .s_out(x_rnd));

   assign req_stall = (st_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data_out = do_ff;
   assign rsp_valid_bytes = vb_ff;
   assign rsp_tag_high = th_ff;
   assign rsp_tag_low = tl_ff;
   assign rsp_tag_match = tm_ff;
   assign rsp_status = stat_ff;

   always_comb begin
      st_in = st_ff;
      act_in = act_ff;
      rnd_in = rnd_ff;
      left_in = left_ff;
      x_in = x_ff;
      phase_in = phase_ff;
      adc_in = adc_ff;
      ads_in = ads_ff;
      rv_in = rv_ff;
      do_in = do_ff;
      vb_in = vb_ff;
      th_in = th_ff;
      tl_in = tl_ff;
      tm_in = tm_ff;
      stat_in = stat_ff;
      m = lead_mask(n_ff);
      dm = d_ff & m;
      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               st_in = S_DISPATCH;
               do_in = '0;
               vb_in = '0;
               th_in = '0;
               tl_in = '0;
               tm_in = 1'b0;
               stat_in = 1'b0;
            end
         end
         S_DISPATCH: begin
            st_in = S_PERM;
            case (cmd_ff)
               CMD_START: begin
                  x_in[0] = IV_WORD;
                  x_in[1] = kh_ff;
                  x_in[2] = kl_ff;
                  x_in[3] = nh_ff;
                  x_in[4] = nl_ff;
                  rnd_in = 4'd0;
                  left_in = 4'(ROUNDS_A);
                  act_in = A_START_END;
               end
               default: begin
                  if ((cmd_ff == CMD_AD && phase_ff != PH_AD) ||
                      (cmd_ff == CMD_TEXT && (phase_ff == PH_IDLE || phase_ff == PH_DONE)) ||
                      (cmd_ff == CMD_FINISH && phase_ff == PH_IDLE)) begin
                     stat_in = 1'b1;
                     st_in = S_RESP;
                  end else if (phase_ff == PH_AD && cmd_ff != CMD_AD) begin
                     // implicit close of associated data
                     if (ads_ff) begin
                        x_in[0] = x_ff[0] ^ PAD_TOP;
                        rnd_in = 4'(ROUNDS_A - ROUNDS_B);
                        left_in = 4'(ROUNDS_B);
                        act_in = A_CLOSE_END;
                     end else begin
                        x_in[4] = x_ff[4] ^ 64'd1;
                        adc_in = 1'b1;
                        phase_in = PH_TEXT;
                        st_in = S_DISPATCH;
                     end
                  end else if (cmd_ff == CMD_AD) begin
                     rnd_in = 4'(ROUNDS_A - ROUNDS_B);
                     left_in = 4'(ROUNDS_B);
                     if (!last_ff || n_ff == 4'd8) begin
                        x_in[0] = x_ff[0] ^ d_ff;
                        ads_in = 1'b1;
                        act_in = last_ff ? A_AD_PAD : A_AD_END;
                     end else if (n_ff == 4'd0 && !ads_ff) begin
                        x_in[4] = x_ff[4] ^ 64'd1;
                        adc_in = 1'b1;
                        phase_in = PH_TEXT;
                        st_in = S_RESP;
                     end else begin
                        x_in[0] = x_ff[0] ^ dm ^ pad_at(n_ff);
                        ads_in = 1'b0;
                        act_in = A_CLOSE_END;
                     end
                  end else if (cmd_ff == CMD_TEXT) begin
                     if (!last_ff || n_ff == 4'd8) begin
                        do_in = d_ff ^ x_ff[0];
                        vb_in = 4'd8;
                        x_in[0] = dec_ff ? d_ff : (d_ff ^ x_ff[0]);
                        rnd_in = 4'(ROUNDS_A - ROUNDS_B);
                        left_in = 4'(ROUNDS_B);
                        act_in = A_TEXT_END;
                     end else begin
                        do_in = (x_ff[0] ^ dm) & m;
                        vb_in = n_ff;
                        x_in[0] = (dec_ff ? (dm | (x_ff[0] & ~m)) : (x_ff[0] ^ dm))
                                  ^ pad_at(n_ff);
                        phase_in = PH_DONE;
                        st_in = S_RESP;
                     end
                  end else begin
                     x_in[0] = (phase_ff == PH_TEXT) ? (x_ff[0] ^ PAD_TOP) : x_ff[0];
                     x_in[1] = x_ff[1] ^ kh_ff;
                     x_in[2] = x_ff[2] ^ kl_ff;
                     rnd_in = 4'd0;
                     left_in = 4'(ROUNDS_A);
                     act_in = A_FIN_END;
                  end
               end
            endcase
         end
         S_PERM: begin
            if (left_ff != 4'd0) begin
               x_in = x_rnd;
               rnd_in = rnd_ff + 4'd1;
               left_in = left_ff - 4'd1;
            end else begin
               st_in = S_RESP;
               case (act_ff)
                  A_START_END: begin
                     x_in[3] = x_ff[3] ^ kh_ff;
                     x_in[4] = x_ff[4] ^ kl_ff;
                     phase_in = PH_AD;
                     adc_in = 1'b0;
                     ads_in = 1'b0;
                  end
                  A_CLOSE_END: begin
                     x_in[4] = x_ff[4] ^ 64'd1;
                     adc_in = 1'b1;
                     phase_in = PH_TEXT;
                     // implicit close goes back to run the actual command
                     if (cmd_ff != CMD_AD) begin
                        st_in = S_DISPATCH;
                     end
                  end
                  A_AD_PAD: begin
                     x_in[0] = x_ff[0] ^ PAD_TOP;
                     rnd_in = 4'(ROUNDS_A - ROUNDS_B);
                     left_in = 4'(ROUNDS_B);
                     act_in = A_CLOSE_END;
                     st_in = S_PERM;
                  end
                  A_TEXT_END: begin
                     if (last_ff) begin
                        x_in[0] = x_ff[0] ^ PAD_TOP;
                        phase_in = PH_DONE;
                     end
                  end
                  A_FIN_END: begin
                     x_in[3] = x_ff[3] ^ kh_ff;
                     x_in[4] = x_ff[4] ^ kl_ff;
                     th_in = x_ff[3] ^ kh_ff;
                     tl_in = x_ff[4] ^ kl_ff;
                     tm_in = dec_ff && ((x_ff[3] ^ kh_ff) == eh_ff) &&
                             ((x_ff[4] ^ kl_ff) == el_ff);
                     phase_in = PH_IDLE;
                     adc_in = 1'b0;
                     ads_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_RESP: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
            end else if (!rsp_stall) begin
               rv_in = 1'b0;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         x_ff <= '0;
         phase_ff <= PH_IDLE;
         adc_ff <= 1'b0;
         ads_ff <= 1'b0;
         rv_ff <= 1'b0;
         kh_ff <= '0;
         kl_ff <= '0;
         nh_ff <= '0;
         nl_ff <= '0;
         dec_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         x_ff <= x_in;
         phase_ff <= phase_in;
         adc_ff <= adc_in;
         ads_ff <= ads_in;
         rv_ff <= rv_in;
         if (csr_write) begin
            case (csr_index)
               REG_KEY_HIGH: kh_ff <= csr_data;
               REG_KEY_LOW: kl_ff <= csr_data;
               REG_NONCE_HIGH: nh_ff <= csr_data;
               REG_NONCE_LOW: nl_ff <= csr_data;
               REG_DECRYPT: dec_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      rnd_ff <= rnd_in;
      left_ff <= left_in;
      do_ff <= do_in;
      vb_ff <= vb_in;
      th_ff <= th_in;
      tl_ff <= tl_in;
      tm_ff <= tm_in;
      stat_ff <= stat_in;
      if (st_ff == S_IDLE && req_valid) begin
         cmd_ff <= req_command;
         d_ff <= req_data_in;
         n_ff <= (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
         last_ff <= req_last_block;
         eh_ff <= req_expected_tag_high;
         el_ff <= req_expected_tag_low;
      end
   end
endmodule
